@@ hw/rtl/iee_pkg.sv @@
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_LP    = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_OTHER = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIVZERO  = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_PARENS   = 3'd3,
        ST_INVALID  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NUMPUSH,
        S_DISPATCH,
        S_FETCH,
        S_DECIDE,
        S_RD_RHS,
        S_RD_LHS,
        S_EXEC,
        S_DIVIDE,
        S_FINISH,
        S_RD_RESULT,
        S_OUTPUT
    } state_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } out_item_t;

    function automatic logic [1:0] rank(input logic [2:0] code);
        case (code)
            OP_ADD, OP_SUB: rank = 2'd1;
            OP_MUL, OP_DIV: rank = 2'd2;
            default:        rank = 2'd0;
        endcase
    endfunction

endpackage

@@ hw/rtl/infix_expression_evaluator_core.sv @@
// Each accepted byte passes the number-push and dispatch states; a digit, a space or '('
// ends there, any other byte also fetches the operator-stack top and may run reductions
// (divisions use the divider); the flagged last byte adds the final reductions and the
// result is presented in the output register. Bytes are taken one at a time, a new one
// only once the block is idle again. A waiting result stalls only the next result.
// Reset: rst_n async-clears state, counts, acc, err, innum, fin, ovalid; stack RAMs hold.
module infix_expression_evaluator_core
    import iee_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // Stack memories: one synchronous read, one write per cycle each.
    logic [31:0] vmem [STACK_DEPTH];
    logic [2:0]  omem [STACK_DEPTH];
    logic [31:0] vrd_reg;
    logic [2:0]  ord_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    logic [31:0] acc_reg, acc_next;
    logic        innum_reg, innum_next;
    logic [2:0]  err_reg, err_next;
    logic [7:0]  ch_reg, ch_next;
    logic        last_reg, last_next;
    logic        fin_reg, fin_next;   // draining the stacks at end of expression
    logic [31:0] rhs_reg, rhs_next;
    logic [2:0]  op_reg, op_next;
    logic [2:0]  code_reg, code_next;
    // Divider: restoring, one quotient bit per cycle.
    logic [31:0] dq_reg, dq_next, drem_reg, drem_next, dden_reg, dden_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic        dneg_reg, dneg_next;
    out_item_t   out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    // Memory access controls.
    logic            vwe, owe, vre, ore;
    logic [SP_W-1:0] vwa, owa, vra, ora;
    logic [31:0]     vwd;
    logic [2:0]      owd;

    logic is_digit, is_space;
    logic [2:0] ch_code;
    logic [31:0] mag_b, acc_dig;
    logic [32:0] trial;

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vwa] <= vwd;
        end
        if (owe)
        begin
            omem[owa] <= owd;
        end
        if (vre)
        begin
            vrd_reg <= vmem[vra];
        end
        if (ore)
        begin
            ord_reg <= omem[ora];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcnt_reg   <= '0;
            ocnt_reg   <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            err_reg    <= ST_OK;
            fin_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vcnt_reg   <= vcnt_next;
            ocnt_reg   <= ocnt_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            err_reg    <= err_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
        rhs_reg  <= rhs_next;
        op_reg   <= op_next;
        code_reg <= code_next;
        dq_reg   <= dq_next;
        drem_reg <= drem_next;
        dden_reg <= dden_next;
        dcnt_reg <= dcnt_next;
        dneg_reg <= dneg_next;
        out_reg  <= out_next;
    end

    assign is_digit = (ch_reg >= "0") && (ch_reg <= "9");
    assign is_space = (ch_reg == " ") || ((ch_reg >= 8'h09) && (ch_reg <= 8'h0D));

    always_comb
    begin
        case (ch_reg)
            "+":     ch_code = OP_ADD;
            "-":     ch_code = OP_SUB;
            "*":     ch_code = OP_MUL;
            "/":     ch_code = OP_DIV;
            default: ch_code = OP_OTHER;
        endcase
    end

    assign mag_b   = rhs_reg[31] ? (32'd0 - rhs_reg) : rhs_reg;
    assign acc_dig = (acc_reg << 3) + (acc_reg << 1) + {28'd0, ch_reg[3:0]};
    assign trial   = {drem_reg, dq_reg[31]} - {1'b0, dden_reg};

    // Accept a new byte whenever idle; a waiting result holds only the next result.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_NUMPUSH;
                end
            end
            S_NUMPUSH:    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                if (err_reg != ST_OK || is_digit || is_space || ch_reg == "(")
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:      state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (err_reg != ST_OK)
                begin
                    state_next = (last_reg || fin_reg) ? S_FINISH : S_IDLE;
                end
                else if (fin_reg)
                begin
                    if (ocnt_reg == '0 || ord_reg == OP_LP)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = (vcnt_reg < CNT_W'(2)) ? S_FINISH : S_RD_RHS;
                    end
                end
                else if (ch_reg == ")")
                begin
                    if (ocnt_reg == '0 || ord_reg == OP_LP)
                    begin
                        state_next = last_reg ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        state_next = (vcnt_reg < CNT_W'(2)) ? S_FINISH : S_RD_RHS;
                        if (vcnt_reg < CNT_W'(2) && !last_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    if (ocnt_reg == '0 || ord_reg == OP_LP || rank(ord_reg) < rank(code_reg))
                    begin
                        state_next = last_reg ? S_FINISH : S_IDLE;
                    end
                    else if (vcnt_reg < CNT_W'(2))
                    begin
                        state_next = last_reg ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD_RHS;
                    end
                end
            end
            S_RD_RHS:     state_next = S_RD_LHS;
            S_RD_LHS:     state_next = S_EXEC;
            S_EXEC:
            begin
                if (op_reg == OP_DIV && rhs_reg != 32'd0)
                begin
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_DIVIDE:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FINISH:
            begin
                if (err_reg == ST_OK && ocnt_reg != '0)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_RD_RESULT;
                end
            end
            S_RD_RESULT:
            begin
                // Hold until the output register is free or drains this cycle.
                if (!ovalid_reg || out_ready)
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        vcnt_next   = vcnt_reg;
        ocnt_next   = ocnt_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        err_next    = err_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        fin_next    = fin_reg;
        rhs_next    = rhs_reg;
        op_next     = op_reg;
        code_next   = code_reg;
        dq_next     = dq_reg;
        drem_next   = drem_reg;
        dden_next   = dden_reg;
        dcnt_next   = dcnt_reg;
        dneg_next   = dneg_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        vwe = 1'b0;
        owe = 1'b0;
        vre = 1'b0;
        ore = 1'b0;
        vwa = vcnt_reg[SP_W-1:0];
        owa = ocnt_reg[SP_W-1:0];
        vra = vcnt_reg[SP_W-1:0] - SP_W'(1);
        ora = ocnt_reg[SP_W-1:0] - SP_W'(1);
        vwd = acc_reg;
        owd = code_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ch_next   = in_data.character;
                    last_next = in_data.end_of_expr;
                    fin_next  = 1'b0;
                end
            end
            S_NUMPUSH:
            begin
                // Digits build the number; any other byte closes the digit run.
                if (err_reg == ST_OK)
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_dig;
                        innum_next = 1'b1;
                        // A digit flagged last closes its own run.
                        if (last_reg)
                        begin
                            innum_next = 1'b0;
                            acc_next   = '0;
                            if (vcnt_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                vwe       = 1'b1;
                                vwd       = acc_dig;
                                vcnt_next = vcnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    else if (innum_reg)
                    begin
                        innum_next = 1'b0;
                        acc_next   = '0;
                        if (vcnt_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            vwe       = 1'b1;
                            vcnt_next = vcnt_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_DISPATCH:
            begin
                code_next = ch_code;
                if (err_reg == ST_OK && ch_reg == "(")
                begin
                    if (ocnt_reg >= CNT_W'(STACK_DEPTH))
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        owe       = 1'b1;
                        owd       = OP_LP;
                        ocnt_next = ocnt_reg + CNT_W'(1);
                    end
                end
            end
            S_FETCH:
            begin
                ore = 1'b1;
            end
            S_DECIDE:
            begin
                if (err_reg == ST_OK)
                begin
                    op_next = ord_reg;
                    if (fin_reg)
                    begin
                        if (ocnt_reg != '0 && ord_reg == OP_LP)
                        begin
                            err_next = ST_PARENS;
                        end
                        else if (ocnt_reg != '0 && vcnt_reg < CNT_W'(2))
                        begin
                            err_next = ST_INVALID;
                        end
                    end
                    else if (ch_reg == ")")
                    begin
                        if (ocnt_reg == '0)
                        begin
                            err_next = ST_PARENS;
                        end
                        else if (ord_reg == OP_LP)
                        begin
                            ocnt_next = ocnt_reg - CNT_W'(1);
                        end
                        else if (vcnt_reg < CNT_W'(2))
                        begin
                            err_next = ST_INVALID;
                        end
                    end
                    else
                    begin
                        if (ocnt_reg == '0 || ord_reg == OP_LP
                            || rank(ord_reg) < rank(code_reg))
                        begin
                            if (ocnt_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                owe       = 1'b1;
                                ocnt_next = ocnt_reg + CNT_W'(1);
                            end
                        end
                        else if (vcnt_reg < CNT_W'(2))
                        begin
                            err_next = ST_INVALID;
                        end
                    end
                end
            end
            S_RD_RHS:
            begin
                vre       = 1'b1;
                ocnt_next = ocnt_reg - CNT_W'(1);
            end
            S_RD_LHS:
            begin
                rhs_next = vrd_reg;
                vre      = 1'b1;
                vra      = vcnt_reg[SP_W-1:0] - SP_W'(2);
            end
            S_EXEC:
            begin
                // Pop both operands; the result lands in the lower slot.
                vcnt_next = vcnt_reg - CNT_W'(2);
                vwa       = vcnt_reg[SP_W-1:0] - SP_W'(2);
                case (op_reg)
                    OP_ADD:
                    begin
                        vwd = vrd_reg + rhs_reg;
                        vwe = 1'b1;
                        vcnt_next = vcnt_reg - CNT_W'(1);
                    end
                    OP_SUB:
                    begin
                        vwd = vrd_reg - rhs_reg;
                        vwe = 1'b1;
                        vcnt_next = vcnt_reg - CNT_W'(1);
                    end
                    OP_MUL:
                    begin
                        vwd = vrd_reg * rhs_reg;
                        vwe = 1'b1;
                        vcnt_next = vcnt_reg - CNT_W'(1);
                    end
                    OP_DIV:
                    begin
                        if (rhs_reg == 32'd0)
                        begin
                            err_next = ST_DIVZERO;
                        end
                        else
                        begin
                            dq_next   = vrd_reg[31] ? (32'd0 - vrd_reg) : vrd_reg;
                            dden_next = mag_b;
                            drem_next = '0;
                            dcnt_next = 6'd31;
                            dneg_next = vrd_reg[31] ^ rhs_reg[31];
                        end
                    end
                    default:
                    begin
                        err_next = ST_UNKNOWN;
                    end
                endcase
            end
            S_DIVIDE:
            begin
                if (trial[32])
                begin
                    drem_next = {drem_reg[30:0], dq_reg[31]};
                    dq_next   = {dq_reg[30:0], 1'b0};
                end
                else
                begin
                    drem_next = trial[31:0];
                    dq_next   = {dq_reg[30:0], 1'b1};
                end
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd0)
                begin
                    vwe       = 1'b1;
                    vwa       = vcnt_reg[SP_W-1:0];
                    vwd       = dneg_reg ? (32'd0 - dq_next) : dq_next;
                    vcnt_next = vcnt_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                fin_next = 1'b1;
                if (err_reg == ST_OK && ocnt_reg == '0 && vcnt_reg != CNT_W'(1))
                begin
                    err_next = ST_INVALID;
                end
                vre = 1'b1;
                vra = '0;
            end
            S_RD_RESULT:
            begin
                // Latch the status and value; clear the block for the next expression.
                if (!ovalid_reg || out_ready)
                begin
                    out_next.status = err_reg;
                    out_next.value  = (err_reg == ST_OK) ? vrd_reg : 32'd0;
                    vcnt_next  = '0;
                    ocnt_next  = '0;
                    acc_next   = '0;
                    innum_next = 1'b0;
                    err_next   = ST_OK;
                    fin_next   = 1'b0;
                end
            end
            S_OUTPUT:
            begin
                ovalid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy)
        else $error("byte accepted while busy");

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n)
        (vcnt_reg <= CNT_W'(STACK_DEPTH)) && (ocnt_reg <= CNT_W'(STACK_DEPTH));
    endproperty
    a_cnt_bound: assert property (p_cnt_bound)
        else $error("stack count beyond depth");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result dropped under stall");

    property p_err_ok_value;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |-> (out_data.value == 32'sd0);
    endproperty
    a_err_ok_value: assert property (p_err_ok_value)
        else $error("nonzero value with error status");

endmodule

@@ tb/sv/iee_checker.sv @@
module iee_checker
    import iee_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending
);

    logic [31:0] vals [STACK_DEPTH];
    int          vcnt;
    logic [2:0]  ops [STACK_DEPTH];
    int          ocnt;
    logic [31:0] acc;
    logic        in_num;
    logic [2:0]  err;
    out_item_t   answers [$];

    assign pending = answers.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void clear_eval();
        vcnt   = 0;
        ocnt   = 0;
        acc    = '0;
        in_num = 1'b0;
        err    = ST_OK;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (err != ST_OK) return;
        if (vcnt >= STACK_DEPTH) begin
            err = ST_OVERFLOW;
            return;
        end
        vals[vcnt] = v;
        vcnt++;
    endfunction

    function automatic void push_opc(input logic [2:0] c);
        if (err != ST_OK) return;
        if (ocnt >= STACK_DEPTH) begin
            err = ST_OVERFLOW;
            return;
        end
        ops[ocnt] = c;
        ocnt++;
    endfunction

    function automatic int prec(input logic [2:0] c);
        if (c == OP_ADD || c == OP_SUB) return 1;
        if (c == OP_MUL || c == OP_DIV) return 2;
        return 0;
    endfunction

    function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void apply_top();
        logic [31:0] l, r, res;
        logic [2:0]  o;
        if (err != ST_OK) return;
        if (vcnt < 2 || ocnt == 0) begin
            err = ST_INVALID;
            return;
        end
        r = vals[vcnt-1];
        l = vals[vcnt-2];
        vcnt -= 2;
        o = ops[ocnt-1];
        ocnt--;
        case (o)
            OP_ADD: res = l + r;
            OP_SUB: res = l - r;
            OP_MUL: res = l * r;
            OP_DIV: begin
                if (r == 0) begin
                    err = ST_DIVZERO;
                    return;
                end
                res = quot(l, r);
            end
            default: begin
                err = ST_UNKNOWN;
                return;
            end
        endcase
        push_val(res);
    endfunction

    function automatic void flush_number();
        if (in_num) begin
            push_val(acc);
            in_num = 1'b0;
            acc    = '0;
        end
    endfunction

    function automatic void eat_char(input logic [7:0] ch);
        logic [2:0] c;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            acc    = acc * 10 + (ch - 8'h30);
            in_num = 1'b1;
            return;
        end
        flush_number();
        if (err != ST_OK) return;
        if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) return;
        if (ch == 8'h28) begin
            push_opc(OP_LP);
            return;
        end
        if (ch == 8'h29) begin
            while (err == ST_OK && ocnt > 0 && ops[ocnt-1] != OP_LP) apply_top();
            if (err != ST_OK) return;
            if (ocnt == 0) begin
                err = ST_PARENS;
                return;
            end
            ocnt--;
            return;
        end
        case (ch)
            8'h2B:   c = OP_ADD;
            8'h2D:   c = OP_SUB;
            8'h2A:   c = OP_MUL;
            8'h2F:   c = OP_DIV;
            default: c = OP_OTHER;
        endcase
        while (err == ST_OK && ocnt > 0) begin
            if (prec(ops[ocnt-1]) < prec(c) || ops[ocnt-1] == OP_LP) break;
            apply_top();
        end
        push_opc(c);
    endfunction

    // Fold one accepted byte into the shadow state; queue an answer on the last.
    function automatic void predict_char(input in_item_t it);
        out_item_t a;
        if (err == ST_OK) eat_char(it.character);
        if (!it.end_of_expr) return;
        if (err == ST_OK) flush_number();
        while (err == ST_OK && ocnt > 0) begin
            if (ops[ocnt-1] == OP_LP) err = ST_PARENS;
            else apply_top();
        end
        if (err == ST_OK && vcnt != 1) err = ST_INVALID;
        a.value  = (err == ST_OK) ? vals[0] : '0;
        a.status = err;
        answers.push_back(a);
        clear_eval();
    endfunction

    initial begin
        fail_count = 0;
        clear_eval();
    end

    always @(posedge clk) begin
        out_item_t w;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    report("unexpected result", out_data.value, '0);
                end
                else begin
                    w = answers.pop_front();
                    if (out_data.status != w.status)
                        report("status", 32'(out_data.status), 32'(w.status));
                    if (out_data.value != w.value)
                        report("value", out_data.value, w.value);
                end
            end
            if (in_valid && in_ready) predict_char(in_data);
        end
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import iee_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        fail_count;
    int        pending;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    int        sent = 0;
    logic [7:0] expr [$];

    localparam int WATCHDOG = 20000;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    infix_expression_evaluator_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    iee_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver stalls about 18 percent of cycles unless in a calm stretch.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 18);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // Send one byte: optional idle gap, then hold valid until the transfer.
    // Drop valid for a cycle after the last byte of an expression.
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{character: ch, end_of_expr: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        if (last) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_expr(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic add_num();
        int n;
        n = $urandom_range(3);
        if (n == 0) expr.push_back(8'("0" + $urandom_range(9)));
        else if (n == 3) begin
            for (int i = 0; i < 10 + $urandom_range(2); i++)
                expr.push_back(8'("0" + $urandom_range(9)));
        end
        else for (int i = 0; i < n; i++) expr.push_back(8'("0" + $urandom_range(9)));
    endtask

    task automatic add_term(input int depth);
        if (depth < 3 && $urandom_range(4) == 0) begin
            expr.push_back("(");
            add_sum(depth + 1);
            expr.push_back(")");
        end
        else add_num();
        if ($urandom_range(5) == 0) expr.push_back(" ");
    endtask

    task automatic add_sum(input int depth);
        string opset;
        int k;
        opset = "+-*/";
        k = $urandom_range(3);
        add_term(depth);
        for (int i = 0; i < k; i++) begin
            expr.push_back(opset[$urandom_range(3)]);
            add_term(depth);
        end
    endtask

    task automatic send_queue();
        for (int i = 0; i < expr.size(); i++) send_char(expr[i], i == expr.size() - 1);
        expr.delete();
    endtask

    task automatic wait_drain();
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        string s;
        int m;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: precedence, parens, extremes, each error kind.
        send_expr("2147483647+1");
        send_expr("(7-10)/2*3");
        send_expr("7/0");
        send_expr("1 2");
        send_expr("3#4");
        send_expr(")");
        send_expr("(1+2");
        send_expr(" ");
        send_expr("4294967296");
        send_expr("2147483648/4294967295");
        send_expr("+");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        s = "";
        for (int i = 0; i < 33; i++) s = {s, "("};
        send_expr(s);
        s = "1";
        for (int i = 0; i < 32; i++) s = {s, "+1"};
        send_expr(s);
        s = "";
        for (int i = 0; i < 33; i++) s = {s, "1 "};
        send_expr(s);
        // Hold off until every answer is back.
        wait_drain();
        repeat (200) @(posedge clk);
        while (sent < 1750) begin
            if (sent > 700 && sent < 1000) calm = 1'b1;
            else calm = 1'b0;
            m = $urandom_range(9);
            if (m < 8) begin
                add_sum(0);
                send_queue();
            end
            else begin
                // Noise: random bytes, any value.
                for (int i = 0; i < 1 + $urandom_range(6); i++)
                    expr.push_back(8'($urandom_range(255)));
                if (m == 9) begin
                    add_sum(0);
                    expr.push_back(")");
                end
                send_queue();
            end
        end
        wait_drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
